/* rtl/edd_pkg.sv */
// Package for the ARGB1555 error-diffusion dither: field widths, register
// indexes, quantizer table and the error-share helper.
// No dependencies.
package edd_pkg;

   localparam int NUM_CH      = 3;
   localparam int CHAN_W      = 8;
   localparam int CODE_W      = 5;
   localparam int PIX_W       = 16;
   localparam int WIDTH_REG_W = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = WIDTH_REG_W;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANT_MODE = 2'd1;

   localparam logic [WIDTH_REG_W-1:0] LINE_WIDTH_RESET = 11'd1024;

   // Quantization error is -7..7; a share is -4..3; a line entry (sum of
   // three shares) is -6..3; a channel sum before clamping is -10..261.
   localparam int ERR_W   = 4;
   localparam int SH_W    = 3;
   localparam int LN_W    = 4;
   localparam int SUM_W   = 10;
   localparam int ENTRY_W = NUM_CH * LN_W;

   localparam logic [CHAN_W-1:0] OPAQUE    = 8'hFF;
   localparam logic [CHAN_W:0]   RND_HALF  = 9'd4;
   localparam logic [CHAN_W:0]   RND_MASK  = ~9'd7;
   localparam logic [CHAN_W:0]   RND_MAX   = 9'd248;
   localparam int                SHARE_SHIFT = 4;

   localparam logic signed [3:0] W_RIGHT = 4'sd7;
   localparam logic signed [3:0] W_BELOW = 4'sd5;
   localparam logic signed [3:0] W_BLEFT = 4'sd3;
   localparam logic signed [3:0] W_BRGHT = 4'sd1;

   typedef logic signed [ERR_W-1:0] qerr_type;
   typedef logic signed [SH_W-1:0]  share_type;
   typedef logic signed [LN_W-1:0]  lerr_type;
   typedef logic [CODE_W-1:0]       code_type;

   // floor(c * 255 / 31)
   localparam logic [CHAN_W-1:0] SCALE_TBL [32] = '{
      8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
      8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
      8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
      8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255};

   // floor(e * k / 16)
   function automatic share_type share(input qerr_type e, input logic signed [3:0] k);
      logic signed [7:0] ext;
      logic signed [7:0] prod;
      ext  = e;
      prod = ext * k;
      return SH_W'(prod >>> SHARE_SHIFT);
   endfunction

endpackage

/* rtl/error_diffusion_dither_argb1555.sv */
// Top level of the ARGB1555 error-diffusion dither: pipeline, line store
// and configuration registers. Depends on edd_pkg.
//
// Converts 8-bit ARGB pixels in raster order to ARGB1555 with Floyd-Steinberg
// error diffusion, one result per pixel. Throughput is one pixel per clock unless
// rsp_ready stalls; pixels pass the compute stage and then the output register.
// The carried right-hand error closes its loop inside the single compute stage,
// and the per-column error line lives in two registered-read RAM banks split
// by column parity, so both writes at the end of a row land in the same cycle.
// A same-cycle write to the entry being read is forwarded. A fill count
// tracks how many columns have been written since reset; columns beyond it
// read as zero, so no clearing pass is needed and the block is ready right
// after reset. Non-opaque pixels (alpha other than 255) give 0 and diffuse
// nothing. line_width 0 acts as 1 and values above MAX_WIDTH as MAX_WIDTH.
module error_diffusion_dither_argb1555 #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [edd_pkg::CHAN_W-1:0]       req_alpha,
   input  logic [edd_pkg::CHAN_W-1:0]       req_red,
   input  logic [edd_pkg::CHAN_W-1:0]       req_green,
   input  logic [edd_pkg::CHAN_W-1:0]       req_blue,
   input  logic                             req_last_row,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [edd_pkg::PIX_W-1:0]        rsp_pixel_out,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [edd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [edd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import edd_pkg::*;

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int HW_W       = $clog2(MAX_WIDTH + 1);
   localparam int BANK_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int CMP_W      = ((COL_W > WIDTH_REG_W) ? COL_W : WIDTH_REG_W) + 1;
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_WIDTH - 1);

   // configuration
   logic [WIDTH_REG_W-1:0] line_width_ff;
   logic                   quant_mode_ff;

   // control
   logic                 accept;
   logic                 b_go;
   logic                 b_valid_ff;
   logic [COL_W-1:0]     column_ff, column_in;
   logic [HW_W-1:0]      hw_ff, hw_in;
   logic [CMP_W-1:0]     col_p1;
   logic                 acc_last;
   logic [BANK_AW-1:0]   rd_addr;
   logic                 rd_bank;
   logic                 fwd_in;
   logic                 rd_ok_in;

   // compute stage
   logic                 b_opaque_ff;
   logic [CHAN_W-1:0]    b_chan_ff [NUM_CH];
   logic                 b_last_row_ff;
   logic [COL_W-1:0]     b_col_ff;
   logic                 b_last_ff;
   logic                 b_sel_ff;
   logic                 rd_ok_ff;
   logic                 fwd_ff;
   logic [ENTRY_W-1:0]   fwd_data_ff;
   logic [ENTRY_W-1:0]   bank_q_ff [2];

   // carried error
   share_type            re_ff [NUM_CH];
   lerr_type             pl_ff [NUM_CH];
   share_type            ph_ff [NUM_CH];

   // output register
   logic                 rsp_valid_ff;
   logic [PIX_W-1:0]     rsp_pixel_ff;

   // datapath
   logic [ENTRY_W-1:0]       below_entry;
   logic signed [SUM_W-1:0]  v     [NUM_CH];
   logic [CHAN_W-1:0]        u     [NUM_CH];
   logic [CHAN_W:0]          t     [NUM_CH];
   logic [CHAN_W-1:0]        q     [NUM_CH];
   logic signed [CHAN_W:0]   diff  [NUM_CH];
   qerr_type                 err   [NUM_CH];
   code_type                 code  [NUM_CH];
   share_type                sh7   [NUM_CH];
   share_type                sh5   [NUM_CH];
   share_type                sh3   [NUM_CH];
   share_type                sh1   [NUM_CH];
   lerr_type                 left  [NUM_CH];
   lerr_type                 here  [NUM_CH];
   share_type                rgt   [NUM_CH];
   logic [ENTRY_W-1:0]       left_word, here_word;
   logic [PIX_W-1:0]         pix;

   // line store writes
   logic                 wr_left, wr_here;
   logic [COL_W-1:0]     idx_left, wr_top;
   logic [HW_W-1:0]      top_n;
   logic                 bank_we [2];
   logic [BANK_AW-1:0]   bank_wa [2];
   logic [ENTRY_W-1:0]   bank_wd [2];

   //------------------------------------------------------------------
   // configuration port
   //------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         quant_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LINE_WIDTH: begin
               line_width_ff <= csr_wdata;
            end
            CSR_QUANT_MODE: begin
               quant_mode_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   //------------------------------------------------------------------
   // handshake and column tracking
   //------------------------------------------------------------------
   assign b_go      = b_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !b_valid_ff || b_go;
   assign accept    = req_valid && req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;

   // row end only depends on position, so it is settled at input time
   assign col_p1    = CMP_W'(column_ff) + CMP_W'(1);
   assign acc_last  = (col_p1 >= CMP_W'(line_width_ff)) || (column_ff == LAST_COL);
   assign column_in = acc_last ? '0 : column_ff + COL_W'(1);

   assign rd_addr  = BANK_AW'(column_ff >> 1);
   assign rd_bank  = column_ff[0];
   assign fwd_in   = bank_we[rd_bank] && (bank_wa[rd_bank] == rd_addr);
   assign rd_ok_in = HW_W'(column_ff) < hw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         column_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         hw_ff        <= '0;
      end else begin
         hw_ff <= hw_in;
         if (accept) begin
            b_valid_ff <= 1'b1;
            column_ff  <= column_in;
         end else if (b_go) begin
            b_valid_ff <= 1'b0;
         end
         if (b_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_opaque_ff   <= (req_alpha == OPAQUE);
         b_chan_ff[0]  <= req_red;
         b_chan_ff[1]  <= req_green;
         b_chan_ff[2]  <= req_blue;
         b_last_row_ff <= req_last_row;
         b_col_ff      <= column_ff;
         b_last_ff     <= acc_last;
         b_sel_ff      <= rd_bank;
         rd_ok_ff      <= rd_ok_in;
         fwd_ff        <= fwd_in;
         fwd_data_ff   <= bank_wd[rd_bank];
      end
      if (b_go) begin
         rsp_pixel_ff <= pix;
      end
   end

   //------------------------------------------------------------------
   // compute stage
   //------------------------------------------------------------------
   assign below_entry = fwd_ff   ? fwd_data_ff :
                        rd_ok_ff ? bank_q_ff[b_sel_ff] : '0;

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         v[c] = SUM_W'($signed({2'b00, b_chan_ff[c]})) + SUM_W'(re_ff[c])
              + SUM_W'($signed(below_entry[c*LN_W +: LN_W]));
         // clamp: sum stays inside -10..261
         if (v[c][SUM_W-1]) begin
            u[c] = '0;
         end else if (v[c][CHAN_W]) begin
            u[c] = '1;
         end else begin
            u[c] = v[c][CHAN_W-1:0];
         end
         t[c] = ({1'b0, u[c]} + RND_HALF) & RND_MASK;
         if (quant_mode_ff) begin
            q[c] = SCALE_TBL[u[c][CHAN_W-1:3]];
         end else if (t[c] > RND_MAX) begin
            q[c] = RND_MAX[CHAN_W-1:0];
         end else begin
            q[c] = t[c][CHAN_W-1:0];
         end
         diff[c] = $signed({1'b0, u[c]}) - $signed({1'b0, q[c]});
         err[c]  = b_opaque_ff ? ERR_W'(diff[c]) : '0;
         code[c] = q[c][CHAN_W-1:3];
         sh7[c]  = share(err[c], W_RIGHT);
         sh5[c]  = share(err[c], W_BELOW);
         sh3[c]  = share(err[c], W_BLEFT);
         sh1[c]  = share(err[c], W_BRGHT);
         left[c] = b_last_row_ff ? '0 : pl_ff[c] + LN_W'(sh3[c]);
         here[c] = b_last_row_ff ? '0 : LN_W'(ph_ff[c]) + LN_W'(sh5[c]);
         rgt[c]  = b_last_row_ff ? '0 : sh1[c];
      end
      left_word = '0;
      here_word = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         left_word[c*LN_W +: LN_W] = left[c];
         here_word[c*LN_W +: LN_W] = here[c];
      end
      pix = b_opaque_ff ? {1'b1, code[0], code[1], code[2]} : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CH; c++) begin
            re_ff[c] <= '0;
            pl_ff[c] <= '0;
            ph_ff[c] <= '0;
         end
      end else if (b_go) begin
         for (int c = 0; c < NUM_CH; c++) begin
            if (b_last_ff) begin
               re_ff[c] <= '0;
               pl_ff[c] <= '0;
               ph_ff[c] <= '0;
            end else begin
               re_ff[c] <= sh7[c];
               pl_ff[c] <= here[c];
               ph_ff[c] <= rgt[c];
            end
         end
      end
   end

   //------------------------------------------------------------------
   // line store: even and odd columns in separate banks
   //------------------------------------------------------------------
   assign wr_left  = b_go && (b_col_ff != '0);
   assign wr_here  = b_go && b_last_ff;
   assign idx_left = b_col_ff - COL_W'(1);
   assign wr_top   = b_last_ff ? b_col_ff : idx_left;
   assign top_n    = HW_W'(wr_top) + HW_W'(1);

   always_comb begin
      hw_in = hw_ff;
      if ((wr_left || wr_here) && (top_n > hw_ff)) begin
         hw_in = top_n;
      end
      for (int b = 0; b < 2; b++) begin
         bank_we[b] = 1'b0;
         bank_wa[b] = BANK_AW'(b_col_ff >> 1);
         bank_wd[b] = here_word;
         if (wr_here && (b_col_ff[0] == 1'(b))) begin
            bank_we[b] = 1'b1;
         end else if (wr_left && (idx_left[0] == 1'(b))) begin
            bank_we[b] = 1'b1;
            bank_wa[b] = BANK_AW'(idx_left >> 1);
            bank_wd[b] = left_word;
         end
      end
   end

   for (genvar gb = 0; gb < 2; gb++) begin : g_bank
      logic [ENTRY_W-1:0] mem [BANK_DEPTH];

      always_ff @(posedge clock) begin
         if (bank_we[gb]) begin
            mem[bank_wa[gb]] <= bank_wd[gb];
         end
         if (accept) begin
            bank_q_ff[gb] <= mem[rd_addr];
         end
      end
   end

   //------------------------------------------------------------------
   // assertions
   //------------------------------------------------------------------
   // line store fills without gaps, so the fill count covers every written entry
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      wr_left |-> (HW_W'(idx_left) <= hw_ff))
      else $error("line store write beyond fill count");

   a_row_end_clear: assert property (@(posedge clock) disable iff (reset)
      (b_go && b_last_ff) |=> (re_ff[0] == '0 && re_ff[1] == '0 && re_ff[2] == '0
                               && pl_ff[0] == '0 && pl_ff[1] == '0 && pl_ff[2] == '0
                               && ph_ff[0] == '0 && ph_ff[1] == '0 && ph_ff[2] == '0))
      else $error("carried error not cleared at row end");

   a_accept_holds: assert property (@(posedge clock) disable iff (reset)
      accept |=> b_valid_ff)
      else $error("accepted transaction lost before compute stage");

   a_column_range: assert property (@(posedge clock) disable iff (reset)
      column_ff <= LAST_COL)
      else $error("column beyond line store");

endmodule
